FILE: design/tt800_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and bit functions for the TT800 generator.
// No dependencies; used by every module of the block.
package tt800_pkg;

	localparam int WORDS  = 25;
	localparam int OFFSET = 7;
	localparam int ADDR_W = $clog2(WORDS);

	localparam logic [31:0] TWIST_CONST = 32'h8ebf_d028;
	localparam logic [31:0] TEMPER_B    = 32'h2b5b_2500;
	localparam logic [31:0] TEMPER_C    = 32'hdb8b_0000;
	localparam logic [63:0] SEED_OR     = 64'h0000_0000_4000_0005;

	// Command codes
	localparam logic [1:0] CMD_NEXT = 2'd0;
	localparam logic [1:0] CMD_SEED = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	// Control from the sequencer to the seed datapath
	typedef struct packed {
		logic load;    // take a new seed
		logic mul_lo;  // lo * lo
		logic mul_hi;  // lo * hi
		logic square;  // assemble u*u mod 2^64
		logic accum;   // u += square | SEED_OR
	} seed_ctl_t;

	function automatic logic [31:0] twist(input logic [31:0] w);
		twist = w[0] ? ({1'b0, w[31:1]} ^ TWIST_CONST) : {1'b0, w[31:1]};
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t1;
		logic [31:0] t2;
		t1 = v ^ ({v[24:0], 7'b0} & TEMPER_B);
		t2 = t1 ^ ({t1[16:0], 15'b0} & TEMPER_C);
		temper = t2 ^ {16'b0, t2[31:16]};
	endfunction

	// h ^ rotl(h,7) ^ rotl(h,23)
	function automatic logic [31:0] seed_mix(input logic [31:0] h);
		seed_mix = h ^ {h[24:0], h[31:25]} ^ {h[8:0], h[31:9]};
	endfunction

endpackage

FILE: design/tt800_state_ram.sv
`timescale 1ns / 1ps
// State word store: one write port, two registered read ports.
// Depends on tt800_pkg for depth and address width.
module tt800_state_ram
	import tt800_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [31:0]       rdata_a,
	output logic [31:0]       rdata_b
);

	logic [31:0] mem_q [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: design/tt800_seed_unit.sv
`timescale 1ns / 1ps
// Seed expansion datapath: one shared 32x32 multiplier and a 64-bit adder.
// Depends on tt800_pkg; stepped by the sequencer in the top level.
module tt800_seed_unit
	import tt800_pkg::*;
(
	input  logic        clk,
	input  seed_ctl_t   ctl,
	input  logic [63:0] seed_value,
	output logic [31:0] mixed_word
);

	logic [63:0] u_q;
	logic [63:0] p_q;
	logic [31:0] q_q;
	logic [63:0] sq_q;
	logic [31:0] mul_b;
	logic [63:0] prod;

	// shared multiplier: low half times low or high half
	assign mul_b = ctl.mul_hi ? u_q[63:32] : u_q[31:0];
	assign prod  = {32'b0, u_q[31:0]} * {32'b0, mul_b};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			u_q <= seed_value;
		end else if (ctl.accum) begin
			u_q <= u_q + (sq_q | SEED_OR);
		end
		if (ctl.mul_lo) begin
			p_q <= prod;
		end
		if (ctl.mul_hi) begin
			q_q <= prod[31:0];
		end
		// u*u mod 2^64 = lo*lo + (lo*hi << 33)
		if (ctl.square) begin
			sq_q <= p_q + {q_q[30:0], 33'b0};
		end
	end

	assign mixed_word = seed_mix(u_q[63:32]);

endmodule

FILE: design/tt800_random_generator_unit.sv
`timescale 1ns / 1ps
// TT800 twisted GFSR generator: sequencer, refresh and tempering.
// Depends on tt800_pkg, tt800_state_ram and tt800_seed_unit.
//
// Usage: drive command and its fields with start high; the transaction is
// taken at a clock edge where start is high and busy is low.
//   next (0): returns one tempered word on random_word, marked by
//     result_valid for exactly one cycle. With words left in the block the
//     strobe follows the S_READ and S_TEMPER states, busy during both.
//     Every 25th output first refreshes all 25 words through the one write
//     port, one word per cycle, in the S_REFRESH state, busy throughout.
//   seed (1): 25 rounds through the shared 32x32 multiplier and 64-bit
//     adder, each stepping through the LL, LH, SQ, ADD and WR states, busy throughout; no result.
//   load (2): writes one raw word in the accepting cycle, busy stays low, no
//     result. Index 25 and above, and command 3, are ignored.
// A new transaction may be accepted in the cycle the strobe is shown.
// The receiver cannot stall: each result is valid for its one cycle only.
// Reset clears the control state and sets the read position so that the
// first next refreshes; words are meaningful only once seeded or loaded.
module tt800_random_generator_unit
	import tt800_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [63:0] seed_value,
	input  logic [4:0]  word_index,
	input  logic [31:0] word_value,
	output logic        result_valid,
	output logic [31:0] random_word
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SEED_LL  = 9'b000000010,
		S_SEED_LH  = 9'b000000100,
		S_SEED_SQ  = 9'b000001000,
		S_SEED_ADD = 9'b000010000,
		S_SEED_WR  = 9'b000100000,
		S_REFRESH  = 9'b001000000,
		S_READ     = 9'b010000000,
		S_TEMPER   = 9'b100000000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(WORDS - 1);
	localparam logic [ADDR_W-1:0] NWORDS  = ADDR_W'(WORDS);
	localparam logic [ADDR_W-1:0] SPLIT   = ADDR_W'(WORDS - OFFSET);
	localparam logic [ADDR_W-1:0] OFS     = ADDR_W'(OFFSET);

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   cnt_q, cnt_d;
	logic [ADDR_W-1:0]   pos_q, pos_d;
	logic                result_valid_q;
	logic [31:0]         random_word_q;

	logic                accept;
	seed_ctl_t           seed_ctl;
	logic [31:0]         mixed_word;

	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [31:0]         wdata;
	logic [ADDR_W-1:0]   raddr_a;
	logic [ADDR_W-1:0]   raddr_b;
	logic [31:0]         rdata_a;
	logic [31:0]         rdata_b;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	tt800_state_ram u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	tt800_seed_unit u_seed (
		.clk        (clk),
		.ctl        (seed_ctl),
		.seed_value (seed_value),
		.mixed_word (mixed_word)
	);

	// Sequencer, memory port steering and seed control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		seed_ctl = '0;
		we       = 1'b0;
		waddr    = cnt_q;
		wdata    = mixed_word;
		raddr_a  = cnt_q;
		raddr_b  = (cnt_q < SPLIT) ? cnt_q + OFS : cnt_q - SPLIT;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_NEXT: begin
							cnt_d   = '0;
							state_d = (pos_q >= NWORDS) ? S_REFRESH : S_READ;
						end
						CMD_SEED: begin
							seed_ctl.load = 1'b1;
							cnt_d         = '0;
							state_d       = S_SEED_LL;
						end
						CMD_LOAD: begin
							if (word_index < NWORDS) begin
								we    = 1'b1;
								waddr = word_index;
								wdata = word_value;
								pos_d = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEED_LL: begin
				seed_ctl.mul_lo = 1'b1;
				state_d         = S_SEED_LH;
			end
			S_SEED_LH: begin
				seed_ctl.mul_hi = 1'b1;
				state_d         = S_SEED_SQ;
			end
			S_SEED_SQ: begin
				seed_ctl.square = 1'b1;
				state_d         = S_SEED_ADD;
			end
			S_SEED_ADD: begin
				seed_ctl.accum = 1'b1;
				state_d        = S_SEED_WR;
			end
			S_SEED_WR: begin
				we    = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					pos_d   = NWORDS;
					state_d = S_IDLE;
				end else begin
					state_d = S_SEED_LL;
				end
			end
			// Read word i and word i+OFFSET, write the previous result
			S_REFRESH: begin
				waddr = cnt_q - 1'b1;
				wdata = rdata_b ^ twist(rdata_a);
				we    = (cnt_q != '0);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == NWORDS) begin
					pos_d   = '0;
					state_d = S_READ;
				end
			end
			S_READ: begin
				raddr_a = pos_q;
				state_d = S_TEMPER;
			end
			S_TEMPER: begin
				pos_d   = pos_q + 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			pos_q          <= NWORDS;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			pos_q          <= pos_d;
			result_valid_q <= (state_q == S_TEMPER);
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (state_q == S_TEMPER) begin
			random_word_q <= temper(rdata_a);
		end
	end

	assign result_valid = result_valid_q;
	assign random_word  = random_word_q;

endmodule

FILE: tb/tt800_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the TT800 generator: tracks the word state and read position,
// predicts each tempered word and compares it with what the block returns.
// Depends on tt800_pkg.
module tt800_checker
	import tt800_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [63:0] seed_value,
	input  logic [4:0]  word_index,
	input  logic [31:0] word_value,
	input  logic        result_valid,
	input  logic [31:0] random_word,
	output int          mismatches,
	output int          outstanding
);

	// Shadow state of the generator
	logic [31:0] shadow_words [WORDS];
	int unsigned shadow_pos;
	logic [31:0] pending_words [$];
	logic [31:0] wanted;

	function automatic logic [31:0] twist_word(input logic [31:0] w);
		logic [31:0] shifted;
		shifted = w >> 1;
		return w[0] ? (shifted ^ TWIST_CONST) : shifted;
	endfunction

	function automatic logic [31:0] temper_word(input logic [31:0] v);
		v = v ^ ((v << 7) & TEMPER_B);
		v = v ^ ((v << 15) & TEMPER_C);
		return v ^ (v >> 16);
	endfunction

	// In-place refresh: the last words see already-updated words from the start
	task automatic refresh_words();
		for (int i = 0; i < WORDS; i++)
			shadow_words[i] = shadow_words[(i + OFFSET) % WORDS] ^ twist_word(shadow_words[i]);
	endtask

	task automatic expand_seed(input logic [63:0] seed);
		logic [63:0] u;
		logic [31:0] h;
		u = seed;
		for (int i = 0; i < WORDS; i++) begin
			u = u + ((u * u) | SEED_OR);
			h = u[63:32];
			shadow_words[i] = h ^ ((h << 7) | (h >> 25)) ^ ((h << 23) | (h >> 9));
		end
		shadow_pos = WORDS;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Results are checked before the transaction of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_words[i])
				shadow_words[i] = '0;
			shadow_pos = WORDS;
			pending_words.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("unexpected random_word %08h", random_word));
				end else begin
					wanted = pending_words.pop_front();
					if (random_word !== wanted)
						report_mismatch($sformatf("random_word %08h, predicted %08h",
							random_word, wanted));
				end
			end
			if (start && !busy) begin
				case (command)
					CMD_NEXT: begin
						if (shadow_pos >= WORDS) begin
							refresh_words();
							shadow_pos = 0;
						end
						pending_words.push_back(temper_word(shadow_words[shadow_pos]));
						shadow_pos++;
					end
					CMD_SEED: expand_seed(seed_value);
					CMD_LOAD: begin
						// out-of-range index leaves everything alone
						if (word_index < WORDS) begin
							shadow_words[word_index] = word_value;
							shadow_pos = 0;
						end
					end
					default: ;
				endcase
			end
			outstanding <= pending_words.size();
		end
	end

endmodule

FILE: tb/tt800_random_generator_unit_test.sv
`timescale 1ns / 1ps
// Top of the TT800 generator testbench: clock, reset, command stimulus,
// watchdog and verdict. Depends on tt800_pkg, the block and tt800_checker.
module tt800_random_generator_unit_test;
	import tt800_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 160;
	localparam int PHASE_ITEMS    = 150;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [63:0] seed_value;
	logic [4:0]  word_index;
	logic [31:0] word_value;
	logic        result_valid;
	logic [31:0] random_word;

	int mismatches;
	int outstanding;
	int idle_pct;
	int items_sent;
	int quiet_cycles;
	int idle_profile [4] = '{0, 88, 28, 0};

	tt800_random_generator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.seed_value   (seed_value),
		.word_index   (word_index),
		.word_value   (word_value),
		.result_valid (result_valid),
		.random_word  (random_word)
	);

	tt800_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.seed_value   (seed_value),
		.word_index   (word_index),
		.word_value   (word_value),
		.result_valid (result_valid),
		.random_word  (random_word),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: cycles with neither an accepted transaction nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// One transaction, preceded by a random gap; returns at the accepting edge
	task automatic issue(input logic [1:0] cmd, input logic [63:0] seed,
			input logic [4:0] idx, input logic [31:0] val);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		seed_value <= seed;
		word_index <= idx;
		word_value <= val;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Next with noise on the unused fields
	task automatic next_word();
		issue(CMD_NEXT, {$urandom, $urandom}, 5'($urandom_range(31)), $urandom);
	endtask

	// Hold off until every predicted word has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int pick;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		command      <= CMD_NEXT;
		seed_value   <= '0;
		word_index   <= '0;
		word_value   <= '0;
		idle_pct   = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: seed extremes, loads at the index limits, ignored commands
		issue(CMD_SEED, 64'h0, 5'd0, 32'h0);
		next_word();
		next_word();
		issue(CMD_LOAD, 64'h0, 5'd0, 32'hffff_ffff);
		issue(CMD_LOAD, 64'hffff_ffff_ffff_ffff, 5'd24, 32'h0);
		issue(CMD_LOAD, 64'h0, 5'd25, 32'h1234_5678);
		issue(CMD_LOAD, 64'h0, 5'd31, 32'hdead_beef);
		issue(CMD_UNUSED, 64'hffff_ffff_ffff_ffff, 5'd31, 32'hffff_ffff);
		next_word();
		next_word();
		issue(CMD_SEED, 64'hffff_ffff_ffff_ffff, 5'd31, 32'hffff_ffff);
		// ignored load must not reset the position: the next still refreshes
		issue(CMD_LOAD, 64'h0, 5'd25, 32'h0);
		issue(CMD_UNUSED, 64'h0, 5'd0, 32'h0);
		next_word();
		issue(CMD_SEED, 64'h8000_0000_0000_0001, 5'd0, 32'h0);
		next_word();
		next_word();
		drain();

		// Random phases with different sender gaps
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_profile[phase];
			while (items_sent < PHASE_ITEMS * (phase + 1)) begin
				pick = $urandom_range(99);
				if (pick < 68) begin
					next_word();
				end else if (pick < 73) begin
					issue(CMD_SEED, {$urandom, $urandom}, 5'($urandom_range(31)),
						$urandom);
				end else if (pick < 91) begin
					issue(CMD_LOAD, {$urandom, $urandom}, 5'($urandom_range(31)),
						$urandom);
				end else if (pick < 95) begin
					issue(CMD_UNUSED, {$urandom, $urandom}, 5'($urandom_range(31)),
						$urandom);
				end else begin
					// full state load, read back through the following nexts
					for (int i = 0; i < WORDS; i++)
						issue(CMD_LOAD, {$urandom, $urandom}, 5'(i), $urandom);
				end
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: tt800_random_generator_unit.f
design/tt800_pkg.sv
design/tt800_state_ram.sv
design/tt800_seed_unit.sv
design/tt800_random_generator_unit.sv
tb/tt800_checker.sv
tb/tt800_random_generator_unit_test.sv
